### rtl/mus_to_midi_event_converter_assert.svh
// Assertion macros shared by the MUS to MIDI converter modules.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef MUS_TO_MIDI_EVENT_CONVERTER_ASSERT_SVH
`define MUS_TO_MIDI_EVENT_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mte_pkg.sv
// Shared types, codes and constants of the MUS to MIDI event converter.
// No dependencies; the parser, serializer and top level refer to it by scoped names.
`default_nettype none

package mte_pkg;

    // Channel storage and configuration port geometry.
    localparam int CHANNELS    = 16;
    localparam int CH_W        = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_VELOCITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_STATUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_COUNT = 2'd2;

    // MUS event type codes (bits 6..4 of the event byte).
    localparam logic [2:0] TYPE_RELEASE    = 3'd0;
    localparam logic [2:0] TYPE_PLAY       = 3'd1;
    localparam logic [2:0] TYPE_BEND       = 3'd2;
    localparam logic [2:0] TYPE_SYSTEM     = 3'd3;
    localparam logic [2:0] TYPE_CONTROLLER = 3'd4;
    localparam logic [2:0] TYPE_SCORE_END  = 3'd6;

    // MIDI status codes and data constants.
    localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
    localparam logic [7:0] STATUS_CTRL      = 8'hB0;
    localparam logic [7:0] STATUS_PROGRAM   = 8'hC0;
    localparam logic [7:0] STATUS_BEND      = 8'hE0;
    localparam logic [7:0] META_STATUS      = 8'hFF;
    localparam logic [7:0] META_END_TRACK   = 8'h2F;
    localparam logic [7:0] BYTE_ZERO        = 8'h00;
    localparam logic [7:0] ARG_ABSENT       = 8'hFF;
    localparam logic [7:0] DATA_MASK        = 8'h7F;
    localparam logic [7:0] RELEASE_VELOCITY = 8'h40;
    localparam logic [7:0] CTRL_MONO        = 8'h7E;
    localparam logic [7:0] CTRL_MAX_INDEX   = 8'd14;
    localparam logic [3:0] MUS_PERC_CHANNEL = 4'd15;
    localparam logic [3:0] MIDI_PERC_CHANNEL = 4'd9;
    localparam logic [CH_W:0] NO_CHANNEL    = 5'h1F;

    // Kind of a queued event record.
    typedef enum logic [1:0] {
        KIND_MIDI = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } mte_kind_t;

    // Configuration registers as seen by the parser.
    typedef struct packed {
        logic                  zero_velocity;
        logic                  running_status;
        logic [CFG_DATA_W-1:0] mono_count;
    } mte_cfg_t;

    // One classified event, without its delay.
    typedef struct packed {
        mte_kind_t  kind;
        logic       send_status;
        logic [7:0] status;
        logic [7:0] first;
        logic [7:0] second;   // ARG_ABSENT when the event has one data byte
    } mte_rec_t;

    // MUS controller index to MIDI controller number.
    function automatic logic [7:0] ctrl_map(input logic [3:0] idx);
        logic [7:0] m;
        unique case (idx)
            4'd0:    m = 8'h00;
            4'd1:    m = 8'h00;
            4'd2:    m = 8'h01;
            4'd3:    m = 8'h07;
            4'd4:    m = 8'h0A;
            4'd5:    m = 8'h0B;
            4'd6:    m = 8'h5B;
            4'd7:    m = 8'h5D;
            4'd8:    m = 8'h40;
            4'd9:    m = 8'h43;
            4'd10:   m = 8'h78;
            4'd11:   m = 8'h7B;
            4'd12:   m = 8'h7E;
            4'd13:   m = 8'h7F;
            4'd14:   m = 8'h79;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/mte_fifo.sv
// Short register queue that carries event records from the parser to the serializer.
// Depends on the assertion macro header only.
`default_nettype none
`include "mus_to_midi_event_converter_assert.svh"

module mte_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count;

    // Pointer arithmetic with one wrap bit to tell full from empty.
    always_comb begin
        count       = wr_ptr_reg - rd_ptr_reg;
        full        = (count == (AW+1)'(DEPTH));
        empty       = (count == '0);
        wr_ptr_next = wr_ptr_reg + (AW+1)'(push);
        rd_ptr_next = rd_ptr_reg + (AW+1)'(pop);
        rd_data     = mem_reg[rd_ptr_reg[AW-1:0]];
    end

    // Pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

    `MTE_ASSERT_NOW(a_no_overflow, push, !full, "queue written while full")
    `MTE_ASSERT_NOW(a_no_underflow, pop, !empty, "queue read while empty")
    `MTE_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count) + 1'b1, "queue not grown")

endmodule

`default_nettype wire

### rtl/mte_front.sv
// Score parser: accepts MUS bytes, tracks per-channel volume and running status,
// and queues one classified record per complete event. Depends on mte_pkg.
`default_nettype none

module mte_front #(
    parameter int MAX_DELAY_BYTES = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mte_pkg::mte_cfg_t          cfg,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_score_byte,
    input  wire logic                       queue_full,
    output logic                            push,
    output mte_pkg::mte_rec_t               rec,
    output logic [7*MAX_DELAY_BYTES-1:0]    rec_delay
);

    localparam int DELAY_W = 7 * MAX_DELAY_BYTES;

    typedef enum logic [8:0] {
        PH_EVENT   = 9'b000000001,
        PH_RELEASE = 9'b000000010,
        PH_PLAY    = 9'b000000100,
        PH_BEND    = 9'b000001000,
        PH_SYS     = 9'b000010000,
        PH_CTRL    = 9'b000100000,
        PH_VALUE   = 9'b001000000,
        PH_DELAY   = 9'b010000000,
        PH_HALT    = 9'b100000000
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [7:0]                status_reg, status_next;
    logic [7:0]                first_reg, first_next;
    logic [7:0]                second_reg, second_next;
    logic [mte_pkg::CH_W-1:0]  chan_reg, chan_next;
    logic                      dly_pres_reg, dly_pres_next;
    logic [DELAY_W-1:0]        acc_reg, acc_next;
    logic [7:0]                vol_reg [mte_pkg::CHANNELS];
    logic [7:0]                last_st_reg [mte_pkg::CHANNELS];
    logic [mte_pkg::CH_W:0]    prev_reg;

    logic                      fire;
    logic [3:0]                mc;
    logic                      finish;
    logic                      emit;
    logic                      vol_we;
    logic [DELAY_W-1:0]        acc_shift;
    logic [7:0]                map_byte;

    // The parser stalls only on a full queue; once halted it drops bytes.
    assign s_ready = (phase_reg == PH_HALT) || !queue_full;
    assign fire    = s_valid && s_ready;

    // MUS channel 15 and MIDI channel 9 trade places.
    always_comb begin
        if (s_score_byte[3:0] == mte_pkg::MUS_PERC_CHANNEL) begin
            mc = mte_pkg::MIDI_PERC_CHANNEL;
        end else if (s_score_byte[3:0] == mte_pkg::MIDI_PERC_CHANNEL) begin
            mc = mte_pkg::MUS_PERC_CHANNEL;
        end else begin
            mc = s_score_byte[3:0];
        end
    end

    assign map_byte  = mte_pkg::ctrl_map(s_score_byte[3:0]);
    assign acc_shift = DELAY_W'({acc_reg, s_score_byte[6:0]});

    // Event decoding.
    always_comb begin
        phase_next    = phase_reg;
        status_next   = status_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        chan_next     = chan_reg;
        dly_pres_next = dly_pres_reg;
        acc_next      = acc_reg;
        finish        = 1'b0;
        emit          = 1'b0;
        vol_we        = 1'b0;
        push          = 1'b0;
        rec           = '0;
        rec.kind      = mte_pkg::KIND_MIDI;
        rec_delay     = acc_reg;

        if (fire) begin
            unique case (phase_reg)
                PH_EVENT: begin
                    chan_next     = mc;
                    dly_pres_next = s_score_byte[7];
                    acc_next      = '0;
                    second_next   = mte_pkg::ARG_ABSENT;
                    unique case (s_score_byte[6:4])
                        mte_pkg::TYPE_RELEASE: begin
                            status_next = cfg.zero_velocity
                                ? {mte_pkg::STATUS_NOTE_ON[7:4], mc}
                                : {mte_pkg::STATUS_NOTE_OFF[7:4], mc};
                            phase_next = PH_RELEASE;
                        end
                        mte_pkg::TYPE_PLAY: begin
                            status_next = {mte_pkg::STATUS_NOTE_ON[7:4], mc};
                            phase_next  = PH_PLAY;
                        end
                        mte_pkg::TYPE_BEND: begin
                            status_next = {mte_pkg::STATUS_BEND[7:4], mc};
                            phase_next  = PH_BEND;
                        end
                        mte_pkg::TYPE_SYSTEM: begin
                            status_next = {mte_pkg::STATUS_CTRL[7:4], mc};
                            phase_next  = PH_SYS;
                        end
                        mte_pkg::TYPE_CONTROLLER: begin
                            status_next = {mte_pkg::STATUS_CTRL[7:4], mc};
                            phase_next  = PH_CTRL;
                        end
                        mte_pkg::TYPE_SCORE_END: begin
                            push       = 1'b1;
                            rec.kind   = mte_pkg::KIND_END;
                            phase_next = PH_HALT;
                        end
                        default: begin
                            push       = 1'b1;
                            rec.kind   = mte_pkg::KIND_ERR;
                            phase_next = PH_HALT;
                        end
                    endcase
                end
                PH_RELEASE: begin
                    first_next  = s_score_byte & mte_pkg::DATA_MASK;
                    second_next = (status_reg[7:4] == mte_pkg::STATUS_NOTE_ON[7:4])
                        ? mte_pkg::BYTE_ZERO : mte_pkg::RELEASE_VELOCITY;
                    finish = 1'b1;
                end
                PH_PLAY: begin
                    first_next = s_score_byte & mte_pkg::DATA_MASK;
                    if (s_score_byte[7]) begin
                        phase_next = PH_VALUE;
                    end else begin
                        second_next = vol_reg[chan_reg];
                        finish      = 1'b1;
                    end
                end
                PH_BEND: begin
                    first_next  = {1'b0, s_score_byte[0], 6'b0};
                    second_next = {1'b0, s_score_byte[7:1]};
                    finish      = 1'b1;
                end
                PH_SYS: begin
                    if (s_score_byte > mte_pkg::CTRL_MAX_INDEX) begin
                        push       = 1'b1;
                        rec.kind   = mte_pkg::KIND_ERR;
                        phase_next = PH_HALT;
                    end else begin
                        first_next  = map_byte;
                        second_next = (map_byte == mte_pkg::CTRL_MONO)
                            ? 8'(cfg.mono_count) : mte_pkg::BYTE_ZERO;
                        finish = 1'b1;
                    end
                end
                PH_CTRL: begin
                    if (s_score_byte == mte_pkg::BYTE_ZERO) begin
                        status_next = {mte_pkg::STATUS_PROGRAM[7:4], chan_reg};
                        phase_next  = PH_VALUE;
                    end else if (s_score_byte > mte_pkg::CTRL_MAX_INDEX) begin
                        push       = 1'b1;
                        rec.kind   = mte_pkg::KIND_ERR;
                        phase_next = PH_HALT;
                    end else begin
                        first_next = map_byte;
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (status_reg[7:4] == mte_pkg::STATUS_NOTE_ON[7:4]) begin
                        second_next = s_score_byte & mte_pkg::DATA_MASK;
                        vol_we      = 1'b1;
                    end else if (status_reg[7:4] == mte_pkg::STATUS_PROGRAM[7:4]) begin
                        first_next  = s_score_byte & mte_pkg::DATA_MASK;
                        second_next = mte_pkg::ARG_ABSENT;
                    end else begin
                        second_next = s_score_byte[7] ? mte_pkg::DATA_MASK : s_score_byte;
                    end
                    finish = 1'b1;
                end
                PH_DELAY: begin
                    acc_next  = acc_shift;
                    rec_delay = acc_shift;
                    emit      = !s_score_byte[7];
                end
                PH_HALT: begin
                end
                default: begin
                    phase_next = PH_HALT;
                end
            endcase

            // Data complete: wait for delay bytes or emit right away.
            if (finish) begin
                if (dly_pres_reg) begin
                    phase_next = PH_DELAY;
                end else begin
                    emit = 1'b1;
                end
            end

            // Queue the finished event and update running status.
            if (emit) begin
                push            = 1'b1;
                rec.kind        = mte_pkg::KIND_MIDI;
                rec.send_status = !cfg.running_status
                    || (status_next != last_st_reg[chan_reg])
                    || ({1'b0, chan_reg} != prev_reg);
                rec.status      = status_next;
                rec.first       = first_next;
                rec.second      = second_next;
                phase_next      = PH_EVENT;
                dly_pres_next   = 1'b0;
                acc_next        = '0;
            end
        end
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_EVENT;
            status_reg   <= '0;
            first_reg    <= '0;
            second_reg   <= mte_pkg::ARG_ABSENT;
            chan_reg     <= '0;
            dly_pres_reg <= 1'b0;
            acc_reg      <= '0;
            prev_reg     <= mte_pkg::NO_CHANNEL;
        end else begin
            phase_reg    <= phase_next;
            status_reg   <= status_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            chan_reg     <= chan_next;
            dly_pres_reg <= dly_pres_next;
            acc_reg      <= acc_next;
            if (emit) begin
                prev_reg <= {1'b0, chan_reg};
            end
        end
    end

    // Per-channel volume and last status.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mte_pkg::CHANNELS; i++) begin
                vol_reg[i]     <= '0;
                last_st_reg[i] <= '0;
            end
        end else begin
            if (vol_we) begin
                vol_reg[chan_reg] <= second_next;
            end
            if (emit) begin
                last_st_reg[chan_reg] <= status_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/mte_back.sv
// Byte serializer: turns the queue head record into MIDI bytes, one per cycle when
// not stalled, through an output register. Depends on mte_pkg and the macro header.
`default_nettype none
`include "mus_to_midi_event_converter_assert.svh"

module mte_back #(
    parameter int MAX_DELAY_BYTES = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      queue_empty,
    input  wire mte_pkg::mte_rec_t         rec,
    input  wire logic [7*MAX_DELAY_BYTES-1:0] rec_delay,
    output logic                           pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [7:0]                     m_midi_byte,
    output logic                           m_last_of_event,
    output logic                           m_score_end,
    output logic                           m_error_flag
);

    localparam int IW = (MAX_DELAY_BYTES > 1) ? $clog2(MAX_DELAY_BYTES) : 1;

    typedef enum logic [8:0] {
        ST_START  = 9'b000000001,
        ST_STATUS = 9'b000000010,
        ST_FIRST  = 9'b000000100,
        ST_SECOND = 9'b000001000,
        ST_DELAY  = 9'b000010000,
        ST_END0   = 9'b000100000,
        ST_END1   = 9'b001000000,
        ST_END2   = 9'b010000000,
        ST_ERR    = 9'b100000000
    } step_t;

    step_t          step_reg, step_next, cur;
    logic [IW-1:0]  idx_reg, idx_next, top_idx;
    logic           go;
    logic [7:0]     byte_out;
    logic           last_out, end_out, err_out;
    logic           valid_reg, valid_next;
    logic [7:0]     byte_reg;
    logic           last_reg, end_reg, err_reg;

    assign go = !queue_empty && (!valid_reg || m_ready);

    // Index of the highest nonzero 7-bit group of the delay.
    always_comb begin
        top_idx = '0;
        for (int i = 1; i < MAX_DELAY_BYTES; i++) begin
            if (rec_delay[7*i +: 7] != 7'd0) begin
                top_idx = IW'(i);
            end
        end
    end

    // Pick the step for the byte to send now.
    always_comb begin
        if (step_reg == ST_START) begin
            priority if (rec.kind == mte_pkg::KIND_END) begin
                cur = ST_END0;
            end else if (rec.kind == mte_pkg::KIND_ERR) begin
                cur = ST_ERR;
            end else if (rec.send_status) begin
                cur = ST_STATUS;
            end else begin
                cur = ST_FIRST;
            end
        end else begin
            cur = step_reg;
        end
    end

    // Byte generation and sequencing.
    always_comb begin
        step_next = step_reg;
        idx_next  = idx_reg;
        byte_out  = mte_pkg::BYTE_ZERO;
        last_out  = 1'b0;
        end_out   = 1'b0;
        err_out   = 1'b0;
        pop       = 1'b0;
        unique case (cur)
            ST_STATUS: begin
                byte_out  = rec.status;
                step_next = ST_FIRST;
            end
            ST_FIRST: begin
                byte_out = rec.first;
                if (rec.second != mte_pkg::ARG_ABSENT) begin
                    step_next = ST_SECOND;
                end else begin
                    step_next = ST_DELAY;
                    idx_next  = top_idx;
                end
            end
            ST_SECOND: begin
                byte_out  = rec.second;
                step_next = ST_DELAY;
                idx_next  = top_idx;
            end
            ST_DELAY: begin
                byte_out = {(idx_reg != '0), rec_delay[7*idx_reg +: 7]};
                if (idx_reg == '0) begin
                    last_out  = 1'b1;
                    pop       = 1'b1;
                    step_next = ST_START;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_END0: begin
                byte_out  = mte_pkg::META_STATUS;
                end_out   = 1'b1;
                step_next = ST_END1;
            end
            ST_END1: begin
                byte_out  = mte_pkg::META_END_TRACK;
                end_out   = 1'b1;
                step_next = ST_END2;
            end
            ST_END2: begin
                byte_out  = mte_pkg::BYTE_ZERO;
                end_out   = 1'b1;
                last_out  = 1'b1;
                pop       = 1'b1;
                step_next = ST_START;
            end
            ST_ERR: begin
                byte_out  = mte_pkg::BYTE_ZERO;
                err_out   = 1'b1;
                last_out  = 1'b1;
                pop       = 1'b1;
                step_next = ST_START;
            end
            default: begin
                step_next = ST_START;
            end
        endcase
        if (!go) begin
            step_next = step_reg;
            idx_next  = idx_reg;
            pop       = 1'b0;
        end
    end

    assign valid_next = go || (valid_reg && !m_ready);

    // Sequencer and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ST_START;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (go) begin
            byte_reg <= byte_out;
            last_reg <= last_out;
            end_reg  <= end_out;
            err_reg  <= err_out;
        end
    end

    assign m_valid         = valid_reg;
    assign m_midi_byte     = byte_reg;
    assign m_last_of_event = last_reg;
    assign m_score_end     = end_reg;
    assign m_error_flag    = err_reg;

    `MTE_ASSERT_NOW(a_err_is_last, valid_reg && err_reg, last_reg, "error byte not marked last")
    `MTE_ASSERT_NOW(a_pop_on_last, pop, last_out && go, "record released before its last byte")
    `MTE_ASSERT_NOW(a_head_held, step_reg != ST_START, !queue_empty, "record left queue mid-event")

endmodule

`default_nettype wire

### rtl/mus_to_midi_event_converter.sv
// Top level of the MUS to MIDI event converter: configuration registers,
// parser, event queue and serializer. Depends on mte_pkg, mte_front, mte_fifo, mte_back.
`default_nettype none

// MUS score bytes enter on s_* and MIDI track bytes leave on m_*. The parser takes
// one score byte per cycle as long as its four-entry event queue has room; after a
// score end or an error it keeps taking bytes and drops them until reset. The
// serializer sends one MIDI byte per cycle, unless m_ready stalls it, from the
// queue head into an output register. A MIDI event has two to seven output bytes,
// a score end three (FF 2F 00) and an error one. The queue lets the parser take
// the bytes of later events while the serializer still sends an earlier one.
// Configuration writes on cfg_* are meant for idle periods.
module mus_to_midi_event_converter #(
    parameter int MAX_DELAY_BYTES = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mte_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_score_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_midi_byte,
    output logic                                 m_last_of_event,
    output logic                                 m_score_end,
    output logic                                 m_error_flag
);

    localparam int DELAY_W = 7 * MAX_DELAY_BYTES;
    localparam int QW      = $bits(mte_pkg::mte_rec_t) + DELAY_W;

    mte_pkg::mte_cfg_t  cfg_reg;
    logic               push, pop, q_full, q_empty;
    mte_pkg::mte_rec_t  wr_rec, rd_rec;
    logic [DELAY_W-1:0] wr_delay, rd_delay;
    logic [QW-1:0]      q_rd;

    // Configuration registers; writes beyond the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mte_pkg::CFG_ZERO_VELOCITY: cfg_reg.zero_velocity <= cfg_data[0];
                mte_pkg::CFG_RUNNING_STATUS: cfg_reg.running_status <= cfg_data[0];
                mte_pkg::CFG_MONO_COUNT: cfg_reg.mono_count <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parser.
    mte_front #(
        .MAX_DELAY_BYTES(MAX_DELAY_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_score_byte(s_score_byte),
        .queue_full  (q_full),
        .push        (push),
        .rec         (wr_rec),
        .rec_delay   (wr_delay)
    );

    // Event queue between parser and serializer.
    mte_fifo #(
        .WIDTH(QW),
        .DEPTH(mte_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wr_data({wr_rec, wr_delay}),
        .full   (q_full),
        .pop    (pop),
        .rd_data(q_rd),
        .empty  (q_empty)
    );

    assign rd_rec   = q_rd[QW-1:DELAY_W];
    assign rd_delay = q_rd[DELAY_W-1:0];

    // Serializer.
    mte_back #(
        .MAX_DELAY_BYTES(MAX_DELAY_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .queue_empty    (q_empty),
        .rec            (rd_rec),
        .rec_delay      (rd_delay),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_midi_byte    (m_midi_byte),
        .m_last_of_event(m_last_of_event),
        .m_score_end    (m_score_end),
        .m_error_flag   (m_error_flag)
    );

endmodule

`default_nettype wire
